/* src/vnep_pkg.sv */
`timescale 1ns / 1ps

package vnep_pkg;

  localparam int BYTE_W      = 8;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // operation codes carried in in_tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // request from the controller to the pool
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [BYTE_W-1:0] wdata;
  } pool_req_t;

endpackage

/* src/vnep_pool.sv */
`timescale 1ns / 1ps

module vnep_pool #(
  parameter int POOL_DEPTH = 64,
  parameter int PTR_W      = $clog2(POOL_DEPTH),
  parameter int FILL_W     = $clog2(POOL_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vnep_pkg::pool_req_t       req,
  output logic [FILL_W-1:0]         fill,
  output logic [vnep_pkg::BYTE_W-1:0] rd_data
);
  import vnep_pkg::*;

  logic [BYTE_W-1:0] mem [POOL_DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [BYTE_W-1:0] rd_data_r;
  logic              full;
  logic              drop;

  assign full = (fill_r == FILL_W'(POOL_DEPTH));
  // push into a full pool drops the oldest byte
  assign drop = req.push && full && !req.pop;

  // pointer and fill update with wrap at the pool depth
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (req.pop || drop) begin
      head_nxt = (head_r == PTR_W'(POOL_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
    end
    if (req.push) begin
      tail_nxt = (tail_r == PTR_W'(POOL_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
    end
    if (req.push && !req.pop && !full) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (req.pop && !req.push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  // byte storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[tail_r] <= req.wdata;
    end
    if (req.pop) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign fill    = fill_r;
  assign rd_data = rd_data_r;

endmodule

/* src/von_neumann_entropy_pool_core.sv */
`timescale 1ns / 1ps
// Von Neumann extractor feeding a byte pool of POOL_DEPTH entries.
// in_ channel: in_tuser[0] selects the operation (0 sample, 1 read);
//   in_tdata holds first_bit, second_bit and read_count.
// out_ channel: one transaction per popped byte, data in out_tdata,
//   out_tlast on the final byte of a read, out_tuser[0] set on the single
//   result of a read that finds nothing to give.
// cfg_we / cfg_wdata write source_enabled; samples are dropped while it is 0.
// A sample leaves in_tready high after it is accepted.
// A read of n bytes (n = min(read_count, fill, 64)) holds in_tready low
//   until its last byte is popped; the pool memory pops one byte per cycle
//   through its registered read port while the receiver keeps up; after the
//   sequencer enters ST_READ each byte passes the pool read register and the
//   output register, streaming one byte per cycle while the receiver keeps up.
// An empty read holds in_tready low while its result waits for the output
//   register.
// A stalled receiver holds the output register; the pop sequencer waits
//   behind one buffered read, so no byte is lost.
// Reset (rst_n low, synchronous) empties the pool and clears the partial
//   byte and source_enabled; stored bytes are not cleared.
module von_neumann_entropy_pool_core #(
  parameter int POOL_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // first_bit, second_bit, read_count[7:0], zero pad
  input  logic [0:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // data_byte
  output logic [0:0]  out_tuser,  // no_data
  output logic        out_tlast
);
  import vnep_pkg::*;

  localparam int FILL_W = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W  = (FILL_W > CNT_W) ? FILL_W : CNT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_NODATA = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic              src_en_r;
  logic [BYTE_W-1:0] partial_r, partial_nxt;
  logic [2:0]        bits_r, bits_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              s1_v_r, s1_v_nxt;
  logic              s1_last_r;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_nodata_r;
  logic              out_last_r;

  pool_req_t         req;
  logic [FILL_W-1:0] fill;
  logic [BYTE_W-1:0] rd_data;

  logic              accept;
  logic              op;
  logic              b1;
  logic              b2;
  logic [7:0]        want;
  logic [CNT_W-1:0]  lim;
  logic [CMP_W-1:0]  fill_ext;
  logic [CMP_W-1:0]  lim_ext;
  logic [CNT_W-1:0]  n_read;
  logic              keep;
  logic              out_free;
  logic              out_load;
  logic              nd_load;
  logic              rd_issue;

  // input field unpacking
  assign op   = in_tuser[0];
  assign b1   = in_tdata[0];
  assign b2   = in_tdata[1];
  assign want = in_tdata[9:2];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_en_r <= 1'b0;
    end else if (cfg_we) begin
      src_en_r <= cfg_wdata;
    end
  end

  // bytes to pop: min of request, fill and the per-read cap
  assign lim      = (want > 8'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : want[CNT_W-1:0];
  assign fill_ext = CMP_W'(fill);
  assign lim_ext  = CMP_W'(lim);
  assign n_read   = (fill_ext < lim_ext) ? fill_ext[CNT_W-1:0] : lim;

  // output handshake and pop issue
  assign out_free = !out_valid_r || out_tready;
  assign out_load = s1_v_r && out_free;
  assign nd_load  = (state_r == ST_NODATA) && !s1_v_r && out_free;
  assign rd_issue = (state_r == ST_READ) && (!s1_v_r || out_load);

  // extractor: keep the first bit of an unequal pair
  assign keep = accept && (op == OP_SAMPLE) && src_en_r && (b1 != b2);

  always_comb begin
    partial_nxt = partial_r;
    bits_nxt    = bits_r;
    req.pop     = rd_issue;
    req.push    = 1'b0;
    req.wdata   = partial_r | (BYTE_W'(b1) << bits_r);
    if (keep) begin
      bits_nxt = bits_r + 3'd1;
      if (bits_r == 3'd7) begin
        req.push    = 1'b1;
        partial_nxt = '0;
      end else begin
        partial_nxt = partial_r | (BYTE_W'(b1) << bits_r);
      end
    end
  end

  // read sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (op == OP_READ)) begin
          if (n_read == '0) begin
            state_nxt = ST_NODATA;
          end else begin
            state_nxt = ST_READ;
            cnt_nxt   = n_read;
          end
        end
      end
      ST_READ: begin
        if (rd_issue) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_NODATA: begin
        if (nd_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // buffered read and output register valid tracking
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (rd_issue) begin
      s1_v_nxt = 1'b1;
    end else if (out_load) begin
      s1_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load || nd_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      partial_r   <= '0;
      bits_r      <= '0;
      cnt_r       <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      partial_r   <= partial_nxt;
      bits_r      <= bits_nxt;
      cnt_r       <= cnt_nxt;
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rd_issue) begin
      s1_last_r <= (cnt_r == CNT_W'(1));
    end
    if (out_load) begin
      out_data_r   <= rd_data;
      out_nodata_r <= 1'b0;
      out_last_r   <= s1_last_r;
    end else if (nd_load) begin
      out_data_r   <= '0;
      out_nodata_r <= 1'b1;
      out_last_r   <= 1'b1;
    end
  end

  vnep_pool #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_pool (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .fill    (fill),
    .rd_data (rd_data)
  );

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_nodata_r;
  assign out_tlast    = out_last_r;

endmodule

/* src/vnep_checker.sv */
`timescale 1ns / 1ps

module vnep_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast
);
  import vnep_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // an empty read result is zero and closes the run
  a_nodata_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && (out_tdata == 8'd0))
    else $error("malformed no-data result");

  // an accepted read blocks the input channel in the next cycle
  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == OP_READ) |=> !in_tready)
    else $error("input ready right after a read");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind von_neumann_entropy_pool_core vnep_checker u_vnep_checker (.*);
